// ----- rtl/gres_pkg.sv -----
// Package for the region evacuation select unit.
// Holds the field widths, code enums, queue entry and status structs shared by all modules.
// No dependencies.
`default_nettype none

package gres_pkg;

  // Region geometry and field widths.
  localparam int unsigned REGION_BYTES = 262144;
  localparam int unsigned REGION_CNT   = 4096;
  localparam int unsigned REGION_SHIFT = $clog2(REGION_BYTES);
  localparam int unsigned LIVE_W       = 31;
  localparam int unsigned ALLOC_W      = 31;
  localparam int unsigned THR_W        = 7;
  localparam int unsigned TAIL_W       = 12;
  localparam int unsigned TAIL_MAX     = (1 << TAIL_W) - 1;

  // Region count spanned by an allocation: ceil(alloc / REGION_BYTES).
  localparam int unsigned SPAN_W       = ALLOC_W - REGION_SHIFT + 1;
  localparam int unsigned PERCENT_SCALE = 100;
  localparam int unsigned THR_RESET     = 75;
  localparam int unsigned LSCALE_W     = LIVE_W + 7;
  localparam int unsigned RPROD_W      = THR_W + SPAN_W;
  localparam int unsigned CMP_W        = RPROD_W + REGION_SHIFT;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Stream widths.
  localparam int unsigned IN_TDATA_W   = 64;
  localparam int unsigned IN_TUSER_W   = 2;
  localparam int unsigned OUT_TDATA_W  = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = THR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE     = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_HEAD  = 2'd2,
    KIND_TAIL  = 2'd3
  } region_kind_t;

  typedef enum logic [1:0] {
    DEC_FREE = 2'd0,
    DEC_EVAC = 2'd1,
    DEC_KEEP = 2'd2
  } decision_t;

  // One classified region as it waits for the back end.
  typedef struct packed {
    region_kind_t             kind;
    logic                     newly;
    logic                     live_valid;
    logic                     last;
    logic                     live_zero;
    logic [TAIL_W-1:0]        head_tails;
    logic [LSCALE_W-1:0]      live_scaled;
    logic [RPROD_W-1:0]       thr_spans;
  } queue_entry_t;

  // Back end status seen by the top level checks.
  typedef struct packed {
    logic pop_last;
    logic tails_zero;
  } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/gres_front.sv -----
// Front end of the region evacuation select unit: accepts descriptors, computes
// the scaled live count, the threshold product and the head tail count.
// Depends on gres_pkg.
`default_nettype none

module gres_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [gres_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [gres_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire logic                              in_tlast,
  input  wire logic [gres_pkg::THR_W-1:0]        threshold,
  input  wire logic                              q_full,
  output logic                                   push,
  output gres_pkg::queue_entry_t                 push_entry
);

  logic                                  f_vld_r;
  logic                                  f_vld_nxt;
  gres_pkg::queue_entry_t                f_ent_r;
  gres_pkg::queue_entry_t                f_ent_nxt;
  logic                                  accept;
  logic [gres_pkg::LIVE_W-1:0]           live;
  logic [gres_pkg::ALLOC_W-1:0]          alloc;
  logic [gres_pkg::ALLOC_W:0]            alloc_up;
  logic [gres_pkg::SPAN_W-1:0]           spans;
  logic [gres_pkg::SPAN_W-1:0]           spans_m1;
  logic [gres_pkg::TAIL_W-1:0]           tails;

  assign in_tready = !f_vld_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = f_vld_r && !q_full;
  assign push_entry = f_ent_r;

  // Field extraction: newly, live_valid, live_bytes, bytes_allocated from the lowest bit.
  assign live  = in_tdata[2 +: gres_pkg::LIVE_W];
  assign alloc = in_tdata[2 + gres_pkg::LIVE_W +: gres_pkg::ALLOC_W];

  // Round the allocation up to whole regions.
  assign alloc_up = {1'b0, alloc} + (gres_pkg::ALLOC_W + 1)'(gres_pkg::REGION_BYTES - 1);
  assign spans    = alloc_up[gres_pkg::ALLOC_W:gres_pkg::REGION_SHIFT];
  assign spans_m1 = spans - gres_pkg::SPAN_W'(1);

  // Tails after a head, saturating; an empty head expects none.
  always_comb begin
    if (spans == '0) begin
      tails = '0;
    end else if (32'(spans_m1) > 32'(gres_pkg::TAIL_MAX)) begin
      tails = gres_pkg::TAIL_W'(gres_pkg::TAIL_MAX);
    end else begin
      tails = gres_pkg::TAIL_W'(spans_m1);
    end
  end

  // Build the classified entry.
  always_comb begin
    f_ent_nxt             = f_ent_r;
    f_vld_nxt             = f_vld_r && !push;
    if (accept) begin
      f_vld_nxt              = 1'b1;
      f_ent_nxt.kind         = gres_pkg::region_kind_t'(in_tuser[1:0]);
      f_ent_nxt.newly        = in_tdata[0];
      f_ent_nxt.live_valid   = in_tdata[1];
      f_ent_nxt.last         = in_tlast;
      f_ent_nxt.live_zero    = (live == '0);
      f_ent_nxt.head_tails   = tails;
      f_ent_nxt.live_scaled  = gres_pkg::LSCALE_W'(live) *
                               gres_pkg::LSCALE_W'(gres_pkg::PERCENT_SCALE);
      f_ent_nxt.thr_spans    = gres_pkg::RPROD_W'(threshold) *
                               gres_pkg::RPROD_W'(spans);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_ent_r <= f_ent_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/gres_queue.sv -----
// Short queue of classified regions between the front and back ends.
// Depends on gres_pkg.
`default_nettype none

module gres_queue (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire gres_pkg::queue_entry_t       push_entry,
  output logic                              full,
  input  wire logic                         pop,
  output logic                              q_valid,
  output gres_pkg::queue_entry_t            q_entry,
  output logic [gres_pkg::QCNT_W-1:0]       count
);

  gres_pkg::queue_entry_t                slot_r [gres_pkg::QUEUE_DEPTH];
  logic [gres_pkg::QPTR_W-1:0]           wr_ptr_r;
  logic [gres_pkg::QPTR_W-1:0]           wr_ptr_nxt;
  logic [gres_pkg::QPTR_W-1:0]           rd_ptr_r;
  logic [gres_pkg::QPTR_W-1:0]           rd_ptr_nxt;
  logic [gres_pkg::QCNT_W-1:0]           count_r;
  logic [gres_pkg::QCNT_W-1:0]           count_nxt;

  assign full    = (32'(count_r) == 32'(gres_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = slot_r[rd_ptr_r];
  assign count   = count_r;

  // Pointer wrap and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == 32'(gres_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + gres_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == 32'(gres_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + gres_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + gres_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - gres_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gres_back.sv -----
// Back end of the region evacuation select unit: tracks large object tails,
// makes the evacuation decision and holds the result register.
// Depends on gres_pkg.
`default_nettype none

module gres_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire gres_pkg::queue_entry_t            q_entry,
  output logic                                   pop,
  input  wire logic                              force_all,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [gres_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output gres_pkg::back_status_t                 status
);

  logic                           o_vld_r;
  logic                           o_vld_nxt;
  gres_pkg::decision_t            o_dec_r;
  logic                           o_err_r;
  logic [gres_pkg::TAIL_W-1:0]    tails_r;
  logic [gres_pkg::TAIL_W-1:0]    tails_nxt;
  logic                           hev_r;
  logic                           hev_nxt;
  gres_pkg::decision_t            dec;
  logic                           err;
  logic                           below;
  logic                           evac;

  assign pop        = q_valid && (!o_vld_r || out_tready);
  assign out_tvalid = o_vld_r;
  assign out_tdata  = {(gres_pkg::OUT_TDATA_W - 3)'(0), o_err_r, o_dec_r};
  assign status.pop_last   = pop && q_entry.last;
  assign status.tails_zero = (tails_r == '0);

  // Live percentage test against the threshold times the rounded allocation.
  assign below = gres_pkg::CMP_W'(q_entry.live_scaled) <
                 {q_entry.thr_spans, gres_pkg::REGION_SHIFT'(0)};

  // Evacuation judgment for allocated regions and heads.
  always_comb begin
    if (force_all || q_entry.newly) begin
      evac = 1'b1;
    end else if (!q_entry.live_valid) begin
      evac = 1'b0;
    end else if (q_entry.kind == gres_pkg::KIND_HEAD) begin
      evac = q_entry.live_zero;
    end else begin
      evac = below;
    end
  end

  // Tail tracking and decision.
  always_comb begin
    dec       = gres_pkg::DEC_FREE;
    err       = 1'b0;
    tails_nxt = tails_r;
    hev_nxt   = hev_r;
    if (tails_r != '0 && q_entry.kind == gres_pkg::KIND_TAIL) begin
      dec       = hev_r ? gres_pkg::DEC_EVAC : gres_pkg::DEC_KEEP;
      tails_nxt = tails_r - gres_pkg::TAIL_W'(1);
    end else begin
      err       = (tails_r != '0);
      tails_nxt = '0;
      unique case (q_entry.kind)
        gres_pkg::KIND_FREE: begin
          dec = gres_pkg::DEC_FREE;
        end
        gres_pkg::KIND_TAIL: begin
          err = 1'b1;
          dec = force_all ? gres_pkg::DEC_EVAC : gres_pkg::DEC_KEEP;
        end
        gres_pkg::KIND_HEAD: begin
          dec       = evac ? gres_pkg::DEC_EVAC : gres_pkg::DEC_KEEP;
          tails_nxt = q_entry.head_tails;
          hev_nxt   = evac;
        end
        default: begin
          dec = evac ? gres_pkg::DEC_EVAC : gres_pkg::DEC_KEEP;
        end
      endcase
    end
    // End of pass clears tail tracking.
    if (q_entry.last) begin
      err       = err || (tails_nxt != '0);
      tails_nxt = '0;
      hev_nxt   = 1'b0;
    end
  end

  assign o_vld_nxt = pop || (o_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      tails_r <= '0;
      hev_r   <= 1'b0;
    end else begin
      o_vld_r <= o_vld_nxt;
      if (pop) begin
        tails_r <= tails_nxt;
        hev_r   <= hev_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      o_dec_r <= dec;
      o_err_r <= err;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gc_region_evacuation_select_unit.sv -----
// Top level of the region evacuation select unit: configuration registers,
// front end, queue and back end. Depends on gres_pkg, gres_front, gres_queue, gres_back.
`default_nettype none

// Takes one region descriptor per cycle while in_tready is high, in address
// order, and returns one decision per region (free, evacuate, keep in place)
// plus an order error flag for broken large object tail sequences.
// Throughput is one item per clock while neither the input nor the result
// is stalled. An accepted item is held in the front register (which forms
// live*100 and threshold*regions spanned), moves into the two-entry queue
// and is then decided by the back end into the result register that drives
// out_tvalid. The back end's tail counter and head evacuation flag are the
// only state carried from item to item. When the result is held off, up
// to four items are in flight (front register, two queue entries and the
// result register) before in_tready drops. The last_region flag travels on
// in_tlast and ends the pass. Configuration must be written only while no
// items are in flight. There is no clearing pass after reset.
module gc_region_evacuation_select_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [gres_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gres_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Region descriptor stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: newly_allocated, live_valid, live_count[30:0], alloc_size[30:0]
  input  wire logic [gres_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: region_kind[1:0]
  input  wire logic [gres_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire logic                              in_tlast,
  // Decision stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata: decision[1:0], order_error, zero padding
  output logic [gres_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  logic                              force_r;
  logic                              force_nxt;
  logic [gres_pkg::THR_W-1:0]        thr_r;
  logic [gres_pkg::THR_W-1:0]        thr_nxt;
  logic                              push;
  gres_pkg::queue_entry_t            push_entry;
  logic                              q_full;
  logic                              pop;
  logic                              q_valid;
  gres_pkg::queue_entry_t            q_entry;
  logic [gres_pkg::QCNT_W-1:0]       q_count;
  gres_pkg::back_status_t            bstat;

  // Configuration register decode.
  always_comb begin
    force_nxt = force_r;
    thr_nxt   = thr_r;
    if (cfg_we) begin
      unique case (gres_pkg::cfg_index_t'(cfg_index))
        gres_pkg::CFG_FORCE:     force_nxt = cfg_wdata[0];
        gres_pkg::CFG_THRESHOLD: thr_nxt   = cfg_wdata[gres_pkg::THR_W-1:0];
        default: begin
          force_nxt = force_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_r <= 1'b0;
      thr_r   <= gres_pkg::THR_W'(gres_pkg::THR_RESET);
    end else begin
      force_r <= force_nxt;
      thr_r   <= thr_nxt;
    end
  end

  gres_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .threshold  (thr_r),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  gres_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .count      (q_count)
  );

  gres_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .force_all  (force_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .status     (bstat)
  );

`ifndef NO_ASSERTIONS
  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_count) <= 32'(gres_pkg::QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // Input backpressure only comes from a full queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_full)
    else $error("input stalled while queue has room");

  // A region marked last leaves no tails pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pop_last |=> bstat.tails_zero)
    else $error("tail count survived end of pass");

  // A valid result never carries the unused decision code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("invalid decision code");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_gc_region_evacuation_select_unit.sv -----
// Self-checking testbench for the region evacuation select unit.
// Drives region descriptors with random gaps and back-pressure, predicts every decision
// in place, and compares it with the result stream. Depends on gres_pkg and the RTL top.
`default_nettype none

module tb_gc_region_evacuation_select_unit;
  import gres_pkg::*;

  localparam longint unsigned RB       = longint'(REGION_BYTES);
  localparam int unsigned     LIVE_MAX = 1 << 30;

  // One region descriptor as it travels on the input stream.
  typedef struct {
    region_kind_t     kind;
    logic             newly;
    logic             live_valid;
    logic [LIVE_W-1:0]  live;
    logic [ALLOC_W-1:0] alloc;
    logic             last;
  } region_desc_t;

  // The outcome predicted for one region.
  typedef struct {
    decision_t decision;
    logic      order_error;
  } region_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predictor copy of the configuration and of the tail tracking state.
  logic                 model_force = 1'b0;
  logic [THR_W-1:0]     model_thr = THR_W'(THR_RESET);
  logic [TAIL_W-1:0]    tails_left = '0;
  logic                 head_evac = 1'b0;

  region_desc_t    pending_regions[$];
  region_verdict_t expected_verdicts[$];

  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned setting_cnt = 0;
  int unsigned evac_cnt = 0;
  int unsigned keep_cnt = 0;
  int unsigned free_cnt = 0;
  int unsigned order_err_cnt = 0;
  int unsigned idle_pct = 30;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;

  gc_region_evacuation_select_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Number of regions covered by an allocation, rounded up.
  function automatic longint unsigned regions_covered(logic [ALLOC_W-1:0] alloc);
    return (longint'(alloc) + RB - 1) / RB;
  endfunction

  // Predicts the decision for one region and advances the tail tracking state.
  function automatic region_verdict_t decide_region(region_desc_t d);
    region_verdict_t v;
    longint unsigned spans;
    longint unsigned tails;
    logic evac;
    v.decision = DEC_FREE;
    v.order_error = 1'b0;
    if (tails_left != 0 && d.kind == KIND_TAIL) begin
      v.decision = head_evac ? DEC_EVAC : DEC_KEEP;
      tails_left = tails_left - 1'b1;
    end else begin
      // A pending tail sequence broken by any other kind is dropped.
      if (tails_left != 0) begin
        v.order_error = 1'b1;
        tails_left = '0;
      end
      if (d.kind == KIND_FREE) begin
        v.decision = DEC_FREE;
      end else if (d.kind == KIND_TAIL) begin
        v.order_error = 1'b1;
        v.decision = model_force ? DEC_EVAC : DEC_KEEP;
      end else begin
        spans = regions_covered(d.alloc);
        if (model_force || d.newly) begin
          evac = 1'b1;
        end else if (!d.live_valid) begin
          evac = 1'b0;
        end else if (d.kind == KIND_HEAD) begin
          evac = (d.live == 0);
        end else begin
          evac = (longint'(d.live) * PERCENT_SCALE) < (longint'(model_thr) * spans * RB);
        end
        v.decision = evac ? DEC_EVAC : DEC_KEEP;
        if (d.kind == KIND_HEAD) begin
          tails = (spans == 0) ? 0 : spans - 1;
          if (tails > TAIL_MAX) begin
            tails = TAIL_MAX;
          end
          tails_left = TAIL_W'(tails);
          head_evac = evac;
        end
      end
    end
    // The end of a pass clears tail tracking; unfinished tails are an error.
    if (d.last) begin
      if (tails_left != 0) begin
        v.order_error = 1'b1;
      end
      tails_left = '0;
      head_evac = 1'b0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fail_cnt < 30) begin
      $display("ERROR at result %0d: %s is %0d, expected %0d", result_cnt, what, got, want);
    end
    fail_cnt++;
  endtask

  // Input driver: offers the next pending region unless it idles this cycle.
  always @(posedge clk) begin : drive_proc
    region_desc_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_regions.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_regions.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {nxt.alloc, nxt.live, nxt.live_valid, nxt.newly};
        in_tuser <= nxt.kind;
        in_tlast <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 80;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: predicts on every accepted region and checks every accepted result.
  always @(posedge clk) begin : check_proc
    region_desc_t    seen;
    region_verdict_t want;
    if (!rst_n) begin
      tails_left = '0;
      head_evac = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        seen.newly = in_tdata[0];
        seen.live_valid = in_tdata[1];
        seen.live = in_tdata[2 +: LIVE_W];
        seen.alloc = in_tdata[2 + LIVE_W +: ALLOC_W];
        seen.kind = region_kind_t'(in_tuser);
        seen.last = in_tlast;
        expected_verdicts.push_back(decide_region(seen));
        accepted_cnt++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result, decision", out_tdata[1:0], 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_tdata[1:0] != want.decision) begin
            report_mismatch("decision", out_tdata[1:0], want.decision);
          end
          if (out_tdata[2] != want.order_error) begin
            report_mismatch("order_error", out_tdata[2], want.order_error);
          end
          case (want.decision)
            DEC_EVAC: evac_cnt++;
            DEC_KEEP: keep_cnt++;
            default:  free_cnt++;
          endcase
          if (want.order_error) begin
            order_err_cnt++;
          end
        end
        result_cnt++;
      end
    end
  end

  task automatic add_region(region_kind_t kind, logic newly, logic live_valid,
                            longint unsigned live, longint unsigned alloc, logic last);
    region_desc_t d;
    d.kind = kind;
    d.newly = newly;
    d.live_valid = live_valid;
    d.live = LIVE_W'(live);
    d.alloc = ALLOC_W'(alloc);
    d.last = last;
    pending_regions.push_back(d);
    queued_cnt++;
  endtask

  // Writes both registers on back-to-back cycles while nothing is in flight.
  task automatic write_config(logic force_all, logic [THR_W-1:0] thr);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FORCE;
    cfg_wdata <= CFG_DATA_W'(force_all);
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_force = force_all;
    model_thr = thr;
    setting_cnt++;
  endtask

  // Waits until every queued region has been accepted and answered.
  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);
  endtask

  // Random descriptor contents, with live counts often placed on the threshold edge.
  function automatic region_desc_t random_region(region_kind_t kind);
    region_desc_t d;
    longint unsigned rounded;
    longint v;
    d.kind = kind;
    d.newly = ($urandom_range(3) == 0);
    d.live_valid = ($urandom_range(7) != 0);
    d.last = 1'b0;
    if (kind == KIND_HEAD) begin
      case ($urandom_range(5))
        0:       d.alloc = '0;
        1:       d.alloc = ALLOC_W'(RB * $urandom_range(1, 6));
        default: d.alloc = ALLOC_W'($urandom_range(1, 6 * RB));
      endcase
      d.live = ($urandom_range(2) == 0) ? '0 : LIVE_W'($urandom_range(0, d.alloc));
    end else begin
      case ($urandom_range(7))
        0:       d.alloc = '0;
        1:       d.alloc = ALLOC_W'($urandom_range(0, LIVE_MAX));
        2:       d.alloc = ALLOC_W'(RB * $urandom_range(1, 8));
        default: d.alloc = ALLOC_W'($urandom_range(1, 4 * RB));
      endcase
      rounded = regions_covered(d.alloc) * RB;
      if (rounded > LIVE_MAX) begin
        rounded = LIVE_MAX;
      end
      case ($urandom_range(5))
        0: d.live = '0;
        1: d.live = LIVE_W'($urandom_range(0, LIVE_MAX));
        2, 3: begin
          v = longint'(rounded * model_thr / PERCENT_SCALE) + $urandom_range(0, 4) - 2;
          if (v < 0) begin
            v = 0;
          end
          if (v > LIVE_MAX) begin
            v = LIVE_MAX;
          end
          d.live = LIVE_W'(v);
        end
        default: d.live = LIVE_W'($urandom_range(0, 32'(rounded)));
      endcase
    end
    return d;
  endfunction

  // Random passes: mostly well-formed head and tail runs, some noise and broken runs.
  task automatic gen_random(int unsigned n_items);
    region_desc_t pass_q[$];
    region_desc_t d;
    int unsigned made;
    int unsigned pass_len;
    int unsigned pick;
    longint unsigned n_tails;
    bit ended;
    made = 0;
    while (made < n_items) begin
      pass_len = $urandom_range(3, 40);
      pass_q.delete();
      ended = 0;
      while (pass_q.size() < pass_len && !ended) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          d = random_region(region_kind_t'($urandom_range(3)));
          d.last = ($urandom_range(7) == 0);
          ended = d.last;
          pass_q.push_back(d);
        end else if (pick < 25) begin
          pass_q.push_back(random_region(KIND_FREE));
        end else if (pick < 60) begin
          pass_q.push_back(random_region(KIND_ALLOC));
        end else begin
          d = random_region(KIND_HEAD);
          pass_q.push_back(d);
          n_tails = regions_covered(d.alloc);
          n_tails = (n_tails == 0) ? 0 : n_tails - 1;
          for (longint unsigned t = 0; t < n_tails; t++) begin
            if ($urandom_range(99) < 3) begin
              // End the pass with tails still owed.
              pass_q[$].last = 1'b1;
              ended = 1;
              break;
            end
            if ($urandom_range(99) < 4) begin
              break;
            end
            pass_q.push_back(random_region(KIND_TAIL));
          end
          if (!ended && $urandom_range(99) < 4) begin
            pass_q.push_back(random_region(KIND_TAIL));
          end
        end
      end
      pass_q[$].last = 1'b1;
      foreach (pass_q[i]) begin
        pending_regions.push_back(pass_q[i]);
        queued_cnt++;
      end
      made += pass_q.size();
    end
  endtask

  // Main sequence: reset, directed regions at reset values, then random phases.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed regions under the reset configuration.
    add_region(KIND_FREE, 1'b1, 1'b1, LIVE_MAX, LIVE_MAX, 1'b0);
    add_region(KIND_ALLOC, 1'b1, 1'b0, 5, RB, 1'b0);
    add_region(KIND_ALLOC, 1'b0, 1'b0, 0, RB, 1'b0);
    add_region(KIND_ALLOC, 1'b0, 1'b1, 0, 0, 1'b0);
    add_region(KIND_ALLOC, 1'b0, 1'b1, 0, 1, 1'b0);
    add_region(KIND_ALLOC, 1'b0, 1'b1, LIVE_MAX, LIVE_MAX, 1'b0);
    add_region(KIND_ALLOC, 1'b0, 1'b1, 196607, RB, 1'b0);
    add_region(KIND_ALLOC, 1'b0, 1'b1, 196608, RB, 1'b0);
    // Head with no tails, then a full head and tail run kept in place.
    add_region(KIND_HEAD, 1'b0, 1'b1, 0, 0, 1'b0);
    add_region(KIND_HEAD, 1'b0, 1'b1, 5, 3 * RB, 1'b0);
    add_region(KIND_TAIL, 1'b0, 1'b0, 0, 0, 1'b0);
    add_region(KIND_TAIL, 1'b1, 1'b1, LIVE_MAX, LIVE_MAX, 1'b0);
    // Tail run broken by an ordinary region.
    add_region(KIND_HEAD, 1'b0, 1'b1, 0, 2 * RB + 1, 1'b0);
    add_region(KIND_TAIL, 1'b0, 1'b1, 0, 0, 1'b0);
    add_region(KIND_ALLOC, 1'b0, 1'b1, 1, RB, 1'b0);
    // Tail with no head in front of it.
    add_region(KIND_TAIL, 1'b0, 1'b1, 0, RB, 1'b0);
    // Pass ends on a head that still owes tails.
    add_region(KIND_HEAD, 1'b0, 1'b0, 0, 2 * RB, 1'b1);
    // Tail count saturates for an oversize head, and the pass ends mid-run.
    add_region(KIND_HEAD, 1'b1, 1'b1, 0, 32'h7FFF_FFFF, 1'b0);
    add_region(KIND_TAIL, 1'b0, 1'b0, 0, 0, 1'b0);
    add_region(KIND_TAIL, 1'b0, 1'b0, 0, 0, 1'b1);
    // After the end of the pass a tail is again out of order.
    add_region(KIND_TAIL, 1'b0, 1'b0, 0, 0, 1'b0);
    add_region(KIND_FREE, 1'b0, 1'b0, 0, 0, 1'b1);
    drain();

    write_config(1'b0, 7'd0);
    gen_random(150);
    drain();

    // Threshold at 100 percent, with a long result stall to back up the input.
    write_config(1'b0, 7'd100);
    gen_random(300);
    while (accepted_cnt + 250 > queued_cnt) begin
      @(posedge clk);
    end
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    drain();

    write_config(1'b1, 7'd50);
    gen_random(150);
    drain();

    write_config(1'b0, 7'd127);
    gen_random(150);
    drain();

    // A stretch with no idling on either side.
    idle_pct <= 0;
    write_config(1'b0, THR_W'($urandom_range(1, 99)));
    gen_random(300);
    drain();

    idle_pct <= 30;
    write_config(1'b0, THR_W'(THR_RESET));
    gen_random(200);
    drain();

    repeat (10) @(posedge clk);
    $display("Checked %0d regions under %0d register settings plus reset values.",
             result_cnt, setting_cnt);
    $display("Outcomes: %0d evacuated, %0d kept, %0d free, %0d with order errors.",
             evac_cnt, keep_cnt, free_cnt, order_err_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("Run timed out with %0d results still outstanding.", expected_verdicts.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
